>>> sv/bil_pkg.sv
// Shared types and constants for the bounded indexed list.
package bil_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned CNT_W         = 7;
   localparam int unsigned POS_W         = 6;
   localparam int unsigned VAL_W         = 32;
   localparam int unsigned REQ_W         = 2;
   localparam int unsigned STAT_W        = 2;
   localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_READ   = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_OOB  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_DELETE,
      OP_LOAD,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [CNT_W-1:0]        count;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] value;
   } cell_ctl_type;

endpackage

>>> sv/bil_cell.sv
// One list cell: an entry (request value or next cell's entry) and a read carry (own entry or next cell's carry).
module bil_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                             clock,
   input  bil_pkg::cell_ctl_type            ctl_i,
   input  logic signed [bil_pkg::VAL_W-1:0] next_entry_i,
   input  logic signed [bil_pkg::VAL_W-1:0] next_carry_i,
   output logic signed [bil_pkg::VAL_W-1:0] entry_o,
   output logic signed [bil_pkg::VAL_W-1:0] carry_o
);
   import bil_pkg::*;

   logic signed [VAL_W-1:0] entry_ff, entry_in;
   logic signed [VAL_W-1:0] carry_ff, carry_in;
   logic                    at_count, at_pos, past_pos;

   always_comb begin
      at_count = (32'(IDX) == 32'(ctl_i.count));
      at_pos   = (32'(IDX) == 32'(ctl_i.pos));
      past_pos = (32'(IDX) >= 32'(ctl_i.pos));
      entry_in = entry_ff;
      carry_in = carry_ff;
      unique case (ctl_i.op)
         OP_APPEND: if (at_count) entry_in = ctl_i.value;
         OP_DELETE: if (past_pos) entry_in = next_entry_i;
         OP_LOAD:   if (at_pos) carry_in = entry_ff;
         OP_SHIFT:  carry_in = next_carry_i;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign entry_o = entry_ff;
   assign carry_o = carry_ff;

endmodule

>>> sv/bil_ctrl.sv
// Request decode, entry count, read sequencing and result register.
module bil_ctrl #(
   parameter int unsigned DEPTH = bil_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bil_pkg::REQ_W-1:0]         req_type,
   input  logic [bil_pkg::POS_W-1:0]         req_position,
   input  logic signed [bil_pkg::VAL_W-1:0]  req_value_in,
   input  logic                              csr_wr_en,
   input  logic [bil_pkg::CNT_W-1:0]         csr_entry_limit,
   input  logic signed [bil_pkg::VAL_W-1:0]  carry_head_i,
   output bil_pkg::cell_ctl_type             ctl_o,
   output logic                              rsp_valid,
   output logic [bil_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [bil_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [bil_pkg::CNT_W-1:0]         rsp_entry_count
);
   import bil_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        limit_ff;
   logic [POS_W-1:0]        shift_ff, shift_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                    accept, in_range, can_append;
   req_code_type            req_code;

   assign accept     = start && (state_ff == ST_IDLE);
   assign req_code   = req_code_type'(req_type);
   assign in_range   = (32'(req_position) < 32'(count_ff));
   assign can_append = (32'(count_ff) < 32'(limit_ff)) && (32'(count_ff) < DEPTH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_code == REQ_READ && in_range) state_in = ST_READ;
         ST_READ: if (shift_ff == '0) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl_o         = '{op: OP_NONE, count: count_ff, pos: req_position, value: req_value_in};
      count_in      = count_ff;
      shift_in      = shift_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = '0;
      rsp_count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code)
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (can_append) begin
                        ctl_o.op     = OP_APPEND;
                        count_in     = count_ff + 7'd1;
                        rsp_count_in = count_ff + 7'd1;
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  REQ_READ: begin
                     if (in_range) begin
                        ctl_o.op = OP_LOAD;
                        shift_in = req_position;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OOB;
                     end
                  end
                  REQ_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (in_range) begin
                        ctl_o.op     = OP_DELETE;
                        count_in     = count_ff - 7'd1;
                        rsp_count_in = count_ff - 7'd1;
                     end else begin
                        rsp_status_in = STAT_OOB;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            if (shift_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = carry_head_i;
            end else begin
               ctl_o.op = OP_SHIFT;
               shift_in = shift_ff - 6'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) limit_ff <= csr_entry_limit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = (state_ff == ST_READ);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count beyond depth");

   a_shift_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && shift_ff != '0) |=> !rsp_valid_ff)
      else $error("result during read shift");

   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && !(req_code == REQ_READ && in_range)) |=> rsp_valid_ff)
      else $error("missing result after request");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_code == REQ_APPEND && can_append) |=>
      (count_ff == $past(count_ff) + 7'd1))
      else $error("append did not advance count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> (rsp_value_ff == '0))
      else $error("error result carries a value");

endmodule

>>> sv/bounded_indexed_list_core.sv
// Bounded indexed list: append, read at index, delete at index over a row of cells.
// A request is taken when start is high and busy is low; each request gives exactly
// one result, shown for one cycle with rsp_valid high, and the receiver cannot stall
// it. Append, delete, out-of-bounds and unused requests give their result in the cycle
// after acceptance and keep busy low, so they can follow back to back. A successful
// read at index p loads the entry into the carry of cell p and moves it down the cell row
// one cell per cycle: busy is high while it moves and falls as the result appears.
module bounded_indexed_list_core #(
   parameter int unsigned DEPTH = bil_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bil_pkg::REQ_W-1:0]         req_type,
   input  logic [bil_pkg::POS_W-1:0]         req_position,
   input  logic signed [bil_pkg::VAL_W-1:0]  req_value_in,
   input  logic                              csr_wr_en,
   input  logic [bil_pkg::CNT_W-1:0]         csr_entry_limit,
   output logic                              rsp_valid,
   output logic [bil_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [bil_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [bil_pkg::CNT_W-1:0]         rsp_entry_count
);
   import bil_pkg::*;

   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] entry [DEPTH+1];
   logic signed [VAL_W-1:0] carry [DEPTH+1];

   assign entry[DEPTH] = '0;
   assign carry[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bil_cell #(
         .IDX (i)
      ) u_cell (
         .clock        (clock),
         .ctl_i        (ctl),
         .next_entry_i (entry[i+1]),
         .next_carry_i (carry[i+1]),
         .entry_o      (entry[i]),
         .carry_o      (carry[i])
      );
   end

   bil_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_value_in    (req_value_in),
      .csr_wr_en       (csr_wr_en),
      .csr_entry_limit (csr_entry_limit),
      .carry_head_i    (carry[0]),
      .ctl_o           (ctl),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

>>> sim/tb_bounded_indexed_list_core.sv
// Self-checking testbench for bounded_indexed_list_core: directed list cases, then random traffic.
module tb_bounded_indexed_list_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bil_pkg::*;

   localparam int unsigned DEPTH          = DEPTH_DEFAULT;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        entry_count;
   } list_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [REQ_W-1:0]        req_type;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_value_in;
   logic                    csr_wr_en;
   logic [CNT_W-1:0]        csr_entry_limit;
   logic                    rsp_valid;
   logic [STAT_W-1:0]       rsp_status;
   logic signed [VAL_W-1:0] rsp_value_out;
   logic [CNT_W-1:0]        rsp_entry_count;

   logic signed [VAL_W-1:0] list_shadow [DEPTH];
   int unsigned             list_count;
   logic [CNT_W-1:0]        list_limit;
   int unsigned             peak_count;
   list_result_type         expected_results [$];
   list_result_type         oldest_result;

   int unsigned idle_pct;
   int unsigned error_count;
   int unsigned results_checked;
   int unsigned quiet_cycles;
   int unsigned append_count;
   int unsigned read_count;
   int unsigned delete_count;
   int unsigned nop_count;
   int unsigned full_count;
   int unsigned oob_count;
   int unsigned limit_writes;

   bounded_indexed_list_core #(.DEPTH(DEPTH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_value_in    (req_value_in),
      .csr_wr_en       (csr_wr_en),
      .csr_entry_limit (csr_entry_limit),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

   always #2 clock = ~clock;

   function automatic list_result_type apply_list_request(req_code_type kind,
                                                         logic [POS_W-1:0] pos,
                                                         logic signed [VAL_W-1:0] value);
      list_result_type result;
      int unsigned     cap;
      int unsigned     i;
      cap = (list_limit > DEPTH) ? DEPTH : int'(list_limit);
      result.status = STAT_OK;
      result.value  = '0;
      case (kind)
         REQ_APPEND: begin
            if (list_count < cap) begin
               list_shadow[list_count] = value;
               list_count++;
            end else begin
               result.status = STAT_FULL;
            end
         end
         REQ_READ: begin
            if (pos < list_count) begin
               result.value = list_shadow[pos];
            end else begin
               result.status = STAT_OOB;
            end
         end
         REQ_DELETE: begin
            if (pos < list_count) begin
               for (i = pos; i + 1 < list_count; i++) begin
                  list_shadow[i] = list_shadow[i + 1];
               end
               list_count--;
            end else begin
               result.status = STAT_OOB;
            end
         end
         default: begin
         end
      endcase
      result.entry_count = list_count[CNT_W-1:0];
      if (list_count > peak_count) begin
         peak_count = list_count;
      end
      return result;
   endfunction

   task automatic send_request(req_code_type kind, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] value);
      list_result_type result;
      start        <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_value_in <= value;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      result = apply_list_request(kind, pos, value);
      expected_results.push_back(result);
      case (kind)
         REQ_APPEND: append_count++;
         REQ_READ:   read_count++;
         REQ_DELETE: delete_count++;
         default:    nop_count++;
      endcase
      if (result.status == STAT_FULL) begin
         full_count++;
      end
      if (result.status == STAT_OOB) begin
         oob_count++;
      end
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // drop start and hold until every outstanding request has its result
   task automatic drain_requests();
      start <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic write_entry_limit(logic [CNT_W-1:0] limit);
      csr_wr_en       <= 1'b1;
      csr_entry_limit <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      list_limit = limit;
      limit_writes++;
      @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_request(REQ_READ, 6'd0, 32'sd0);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      send_request(REQ_READ, 6'd63, -32'sd1);
      send_request(REQ_NOP, 6'd63, $urandom);
      drain_requests();
   endtask

   task automatic test_append_read_delete();
      send_request(REQ_APPEND, 6'd0, 32'sh8000_0000);
      send_request(REQ_APPEND, 6'd63, 32'sh7fff_ffff);
      send_request(REQ_APPEND, 6'd21, 32'sd0);
      send_request(REQ_APPEND, 6'd42, -32'sd1);
      send_request(REQ_APPEND, 6'd0, 32'sh5a5a_a5a5);
      for (int p = 0; p <= 5; p++) begin
         send_request(REQ_READ, p[POS_W-1:0], 32'sd0);
      end
      send_request(REQ_DELETE, 6'd2, 32'sd0);
      send_request(REQ_READ, 6'd2, 32'sd0);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      send_request(REQ_DELETE, 6'd2, 32'sd0);
      send_request(REQ_READ, 6'd2, 32'sd0);
      send_request(REQ_NOP, 6'd1, 32'sh8000_0000);
      send_request(REQ_READ, 6'd1, 32'sd0);
      drain_requests();
   endtask

   task automatic test_limit_settings();
      write_entry_limit(7'd3);
      send_request(REQ_APPEND, 6'd0, 32'sd11);
      send_request(REQ_APPEND, 6'd0, 32'sd12);
      send_request(REQ_APPEND, 6'd0, 32'sd13);
      drain_requests();
      write_entry_limit(7'd0);
      send_request(REQ_APPEND, 6'd0, 32'sd14);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      drain_requests();
      write_entry_limit(7'd1);
      send_request(REQ_APPEND, 6'd0, 32'sd15);
      send_request(REQ_READ, 6'd2, 32'sd0);
      send_request(REQ_DELETE, 6'd2, 32'sd0);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      send_request(REQ_APPEND, 6'd0, 32'sd16);
      send_request(REQ_APPEND, 6'd0, 32'sd17);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      drain_requests();
   endtask

   task automatic test_full_depth();
      write_entry_limit(7'd127);
      while (list_count < DEPTH) begin
         send_request(REQ_APPEND, POS_W'($urandom_range(0, 63)), $urandom);
      end
      send_request(REQ_APPEND, 6'd0, $urandom);
      send_request(REQ_READ, 6'd63, 32'sd0);
      send_request(REQ_DELETE, 6'd63, 32'sd0);
      send_request(REQ_READ, 6'd63, 32'sd0);
      send_request(REQ_DELETE, 6'd0, 32'sd0);
      send_request(REQ_READ, 6'd61, 32'sd0);
      drain_requests();
      write_entry_limit(7'd65);
      send_request(REQ_APPEND, 6'd0, $urandom);
      send_request(REQ_APPEND, 6'd0, $urandom);
      send_request(REQ_APPEND, 6'd0, $urandom);
      drain_requests();
      write_entry_limit(LIMIT_RESET);
      while (list_count != 0) begin
         send_request(REQ_DELETE, POS_W'($urandom_range(0, list_count - 1)), $urandom);
         if ($urandom_range(0, 3) == 0 && list_count != 0) begin
            send_request(REQ_READ, POS_W'($urandom_range(0, list_count - 1)), $urandom);
         end
      end
      send_request(REQ_READ, 6'd0, 32'sd0);
      drain_requests();
   endtask

   task automatic test_random_traffic(int unsigned segments, int unsigned items_per_segment,
                                      bit with_idle);
      logic [CNT_W-1:0]        limit;
      req_code_type            kind;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] value;
      int unsigned             append_bias;
      int unsigned             pick;
      for (int s = 0; s < segments; s++) begin
         case ($urandom_range(0, 9))
            0:       limit = 7'd0;
            1:       limit = 7'd1;
            2:       limit = 7'd2;
            3:       limit = 7'd63;
            4:       limit = 7'd64;
            5:       limit = 7'd65;
            6:       limit = 7'd127;
            default: limit = CNT_W'($urandom_range(0, 127));
         endcase
         write_entry_limit(limit);
         append_bias = $urandom_range(20, 70);
         for (int n = 0; n < items_per_segment; n++) begin
            if (n % 32 == 0) begin
               idle_pct = (with_idle && $urandom_range(0, 2) != 0) ? $urandom_range(10, 40) : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < append_bias) begin
               kind = REQ_APPEND;
            end else if (pick < 96) begin
               kind = ($urandom_range(0, 1) == 0) ? REQ_READ : REQ_DELETE;
            end else begin
               kind = REQ_NOP;
            end
            if (list_count != 0 && $urandom_range(0, 99) < 85) begin
               pos = POS_W'($urandom_range(0, list_count - 1));
            end else begin
               pos = POS_W'($urandom_range(0, 63));
            end
            case ($urandom_range(0, 9))
               0:       value = 32'sh8000_0000;
               1:       value = 32'sh7fff_ffff;
               default: value = $urandom;
            endcase
            send_request(kind, pos, value);
         end
         idle_pct = 0;
         drain_requests();
      end
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d value_out %0d entry_count %0d",
                   rsp_status, rsp_value_out, rsp_entry_count);
            error_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            results_checked++;
            if (rsp_status !== oldest_result.status) begin
               $error("status: expected %0d, actual %0d", oldest_result.status, rsp_status);
               error_count++;
            end
            if (rsp_value_out !== oldest_result.value) begin
               $error("value_out: expected %0d, actual %0d", oldest_result.value, rsp_value_out);
               error_count++;
            end
            if (rsp_entry_count !== oldest_result.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", oldest_result.entry_count,
                      rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles with no activity", quiet_cycles);
         $display("bounded_indexed_list_core test failed");
         $finish;
      end
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_type        <= REQ_NOP;
      req_position    <= '0;
      req_value_in    <= '0;
      csr_wr_en       <= 1'b0;
      csr_entry_limit <= LIMIT_RESET;
      list_count      = 0;
      list_limit      = LIMIT_RESET;
      peak_count      = 0;
      idle_pct        = 0;
      error_count     = 0;
      results_checked = 0;
      quiet_cycles    = 0;
      append_count    = 0;
      read_count      = 0;
      delete_count    = 0;
      nop_count       = 0;
      full_count      = 0;
      oob_count       = 0;
      limit_writes    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_append_read_delete();
      test_limit_settings();
      test_full_depth();
      test_random_traffic(7, 130, 1'b1);
      test_random_traffic(2, 130, 1'b0);

      drain_requests();
      repeat (DEPTH + 6) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      $display("requests: %0d append, %0d read, %0d delete, %0d unused code; %0d full, %0d out of bounds",
               append_count, read_count, delete_count, nop_count, full_count, oob_count);
      $display("%0d results checked, %0d limit writes, peak length %0d, %0d errors",
               results_checked, limit_writes, peak_count, error_count);
      if (error_count == 0) begin
         $display("bounded_indexed_list_core test passed");
      end else begin
         $display("bounded_indexed_list_core test failed");
      end
      $finish;
   end

endmodule
